// ===== rtl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debounce / autorepeat core.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] CFG_FIRST_REPEAT = 2'd1;
  localparam logic [1:0] CFG_REPEAT       = 2'd2;
  localparam logic [1:0] CFG_REPRESS_WIN  = 2'd3;

  localparam int unsigned DB_W    = 10;
  localparam int unsigned RPT_W   = 12;
  localparam int unsigned SINCE_W = 12;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 12;

  // Reset values of the configuration registers
  localparam logic [DB_W-1:0]  DEBOUNCE_RST     = 10'd25;
  localparam logic [RPT_W-1:0] FIRST_REPEAT_RST = 12'd750;
  localparam logic [RPT_W-1:0] REPEAT_RST       = 12'd250;
  localparam logic [RPT_W-1:0] REPRESS_WIN_RST  = 12'd500;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_REPRESS = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REPEAT  = 2'd3
  } ev_kind_t;

  // One button's event within a tick
  typedef struct packed {
    ev_kind_t         kind;
    logic [CNT_W-1:0] count;
  } evt_t;

  localparam int unsigned EVT_W = $bits(evt_t);

  // Queue status seen by the core and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage : bda_pkg

`default_nettype wire

// ===== rtl/button_debounce_autorepeat_core.sv =====
// With the serializer idle, a tick's first event passes through the event queue, the
// serializer's event registers and the output register before it is presented.
// The serializer presents one event per cycle while out_ready is high; a tick holds
// at most BUTTON_COUNT events, and ticks without events are not queued.
// A tick request is taken whenever the two-entry event queue has room.
// Reset (rst_n low, synchronous) clears all button state, restores the
// register defaults 25/750/250/500 and empties the queue and output stage.
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core
// Debounces a bank of buttons and emits press, repress, release and repeat
// events, one per cycle while out_ready is high, lowest button first in a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_core #(
  parameter int unsigned BUTTON_COUNT = 5,
  localparam int unsigned IDX_W       = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [BUTTON_COUNT-1:0]      in_raw_levels,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [IDX_W-1:0]             out_button_index,
  output logic [1:0]                   out_event_kind,
  output logic [bda_pkg::CNT_W-1:0]    out_press_count,
  output logic                         out_last_event,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [1:0]                   cfg_index,
  input  wire  [bda_pkg::CFG_W-1:0]    cfg_data
);
  import bda_pkg::*;

  localparam int unsigned Q_W = BUTTON_COUNT * (1 + EVT_W);

  logic                           tick_accept;
  logic                           ev_push;
  logic [BUTTON_COUNT-1:0]        ev_mask;
  evt_t [BUTTON_COUNT-1:0]        ev_data;
  fifo_stat_t                     q_stat;
  logic                           q_pop;
  logic [Q_W-1:0]                 q_rd;
  logic [BUTTON_COUNT-1:0]        q_mask;
  evt_t [BUTTON_COUNT-1:0]        q_data;

  assign in_ready    = !q_stat.full;
  assign cfg_ready   = 1'b1;
  assign tick_accept = in_valid && in_ready;

  // Front: timers and classification
  bda_front #(.BUTTON_COUNT(BUTTON_COUNT)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_accept (tick_accept),
    .raw_levels  (in_raw_levels),
    .cfg_accept  (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ev_push     (ev_push),
    .ev_mask     (ev_mask),
    .ev_data     (ev_data)
  );

  // Event queue, one entry per tick with events
  bda_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data ({ev_mask, ev_data}),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .stat      (q_stat)
  );

  assign {q_mask, q_data} = q_rd;

  // Back: event serializer and output register
  bda_back #(.BUTTON_COUNT(BUTTON_COUNT), .IDX_W(IDX_W)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_mask           (q_mask),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_event_kind   (out_event_kind),
    .out_press_count  (out_press_count),
    .out_last_event   (out_last_event)
  );

`ifndef SYNTHESIS
  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !q_stat.full)
    else $error("event queue overflow");

  // Queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("event queue underflow");

  // A plain press always carries a zero count
  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == EV_PRESS)) |-> (out_press_count == '0))
    else $error("press event with nonzero count");

  // Events only name existing buttons
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_button_index < IDX_W'(BUTTON_COUNT - 1) ||
                   out_button_index == IDX_W'(BUTTON_COUNT - 1)))
    else $error("button index out of range");
`endif

endmodule : button_debounce_autorepeat_core

`default_nettype wire

// ===== rtl/bda_fifo.sv =====
// ----------------------------------------------------------------------------
// bda_fifo
// Small register queue between the tick front end and the event serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire  [WIDTH-1:0]        push_data,
  input  wire                     pop,
  output logic [WIDTH-1:0]        pop_data,
  output bda_pkg::fifo_stat_t     stat
);
  import bda_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_L = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_L-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W_L'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : bda_fifo

`default_nettype wire

// ===== rtl/bda_front.sv =====
// ----------------------------------------------------------------------------
// bda_front
// Per-tick debounce and repeat timers; classifies each button's event.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_front #(
  parameter int unsigned BUTTON_COUNT = 5
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   tick_accept,
  input  wire  [BUTTON_COUNT-1:0]               raw_levels,
  input  wire                                   cfg_accept,
  input  wire  [1:0]                            cfg_index,
  input  wire  [bda_pkg::CFG_W-1:0]             cfg_data,
  output logic                                  ev_push,
  output logic [BUTTON_COUNT-1:0]               ev_mask,
  output bda_pkg::evt_t [BUTTON_COUNT-1:0]      ev_data
);
  import bda_pkg::*;

  // Configuration registers
  logic [DB_W-1:0]  debounce_ticks_r;
  logic [RPT_W-1:0] first_repeat_ticks_r;
  logic [RPT_W-1:0] repeat_ticks_r;
  logic [RPT_W-1:0] repress_win_r;

  // Per-button state
  logic [BUTTON_COUNT-1:0] prev_raw_r;
  logic [BUTTON_COUNT-1:0] stable_r,   stable_nxt;
  logic [BUTTON_COUNT-1:0] db_armed_r, db_armed_nxt;
  logic [BUTTON_COUNT-1:0] rp_armed_r, rp_armed_nxt;
  logic [DB_W-1:0]    db_rem_r [BUTTON_COUNT];
  logic [DB_W-1:0]    db_rem_nxt [BUTTON_COUNT];
  logic [RPT_W-1:0]   rp_rem_r [BUTTON_COUNT];
  logic [RPT_W-1:0]   rp_rem_nxt [BUTTON_COUNT];
  logic [SINCE_W-1:0] since_r [BUTTON_COUNT];
  logic [SINCE_W-1:0] since_nxt [BUTTON_COUNT];
  logic [CNT_W-1:0]   held_r [BUTTON_COUNT];
  logic [CNT_W-1:0]   held_nxt [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] loaded;

  // Next state and events, buttons independent of each other
  always_comb begin
    stable_nxt   = stable_r;
    db_armed_nxt = db_armed_r;
    rp_armed_nxt = rp_armed_r;
    ev_mask      = '0;
    loaded       = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      db_rem_nxt[i]    = db_rem_r[i];
      rp_rem_nxt[i]    = rp_rem_r[i];
      held_nxt[i]      = held_r[i];
      since_nxt[i]     = (since_r[i] != SINCE_MAX) ? since_r[i] + 1'b1 : since_r[i];
      ev_data[i].kind  = EV_PRESS;
      ev_data[i].count = '0;

      // debounce
      if (raw_levels[i] != prev_raw_r[i]) begin
        db_rem_nxt[i]   = debounce_ticks_r;
        db_armed_nxt[i] = 1'b1;
      end else if (db_armed_r[i]) begin
        if (db_rem_r[i] <= DB_W'(1)) begin
          db_rem_nxt[i]   = '0;
          db_armed_nxt[i] = 1'b0;
          if (raw_levels[i] != stable_r[i]) begin
            stable_nxt[i] = raw_levels[i];
            ev_mask[i]    = 1'b1;
            if (raw_levels[i]) begin
              rp_rem_nxt[i]   = first_repeat_ticks_r;
              rp_armed_nxt[i] = 1'b1;
              loaded[i]       = 1'b1;
              if ((since_nxt[i] < repress_win_r) && (held_r[i] != '0)) begin
                ev_data[i].kind  = EV_REPRESS;
                ev_data[i].count = held_r[i];
              end else begin
                held_nxt[i]      = '0;
                ev_data[i].kind  = EV_PRESS;
                ev_data[i].count = '0;
              end
            end else begin
              since_nxt[i]     = '0;
              rp_armed_nxt[i]  = 1'b0;
              rp_rem_nxt[i]    = '0;
              ev_data[i].kind  = EV_RELEASE;
              ev_data[i].count = held_r[i];
            end
          end
        end else begin
          db_rem_nxt[i] = db_rem_r[i] - 1'b1;
        end
      end

      // autorepeat
      if (rp_armed_nxt[i] && !loaded[i]) begin
        if (rp_rem_nxt[i] <= RPT_W'(1)) begin
          if (stable_nxt[i]) begin
            rp_rem_nxt[i]    = repeat_ticks_r;
            held_nxt[i]      = (held_nxt[i] != COUNT_MAX) ? held_nxt[i] + 1'b1 : held_nxt[i];
            ev_mask[i]       = 1'b1;
            ev_data[i].kind  = EV_REPEAT;
            ev_data[i].count = held_nxt[i];
          end else begin
            rp_armed_nxt[i] = 1'b0;
            rp_rem_nxt[i]   = '0;
          end
        end else begin
          rp_rem_nxt[i] = rp_rem_nxt[i] - 1'b1;
        end
      end
    end
  end

  // Ticks without events are not queued
  assign ev_push = tick_accept && (ev_mask != '0);

  // Button state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= '0;
      stable_r   <= '0;
      db_armed_r <= '0;
      rp_armed_r <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        db_rem_r[i] <= '0;
        rp_rem_r[i] <= '0;
        since_r[i]  <= SINCE_MAX;
        held_r[i]   <= '0;
      end
    end else if (tick_accept) begin
      prev_raw_r <= raw_levels;
      stable_r   <= stable_nxt;
      db_armed_r <= db_armed_nxt;
      rp_armed_r <= rp_armed_nxt;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        db_rem_r[i] <= db_rem_nxt[i];
        rp_rem_r[i] <= rp_rem_nxt[i];
        since_r[i]  <= since_nxt[i];
        held_r[i]   <= held_nxt[i];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r     <= DEBOUNCE_RST;
      first_repeat_ticks_r <= FIRST_REPEAT_RST;
      repeat_ticks_r       <= REPEAT_RST;
      repress_win_r        <= REPRESS_WIN_RST;
    end else if (cfg_accept) begin
      case (cfg_index)
        CFG_DEBOUNCE:     debounce_ticks_r     <= cfg_data[DB_W-1:0];
        CFG_FIRST_REPEAT: first_repeat_ticks_r <= cfg_data[RPT_W-1:0];
        CFG_REPEAT:       repeat_ticks_r       <= cfg_data[RPT_W-1:0];
        CFG_REPRESS_WIN:  repress_win_r        <= cfg_data[RPT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule : bda_front

`default_nettype wire

// ===== rtl/bda_back.sv =====
// ----------------------------------------------------------------------------
// bda_back
// Serializes one tick's events, lowest button first, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_back #(
  parameter int unsigned BUTTON_COUNT = 5,
  parameter int unsigned IDX_W        = 3
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  bda_pkg::fifo_stat_t                   q_stat,
  input  wire  [BUTTON_COUNT-1:0]               q_mask,
  input  bda_pkg::evt_t [BUTTON_COUNT-1:0]      q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [IDX_W-1:0]                      out_button_index,
  output logic [1:0]                            out_event_kind,
  output logic [bda_pkg::CNT_W-1:0]             out_press_count,
  output logic                                  out_last_event
);
  import bda_pkg::*;

  logic [BUTTON_COUNT-1:0]         mask_r, mask_nxt;
  evt_t [BUTTON_COUNT-1:0]         evs_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]                idx_r;
  evt_t                            evt_out_r;
  logic                            last_r;
  logic                            adv;
  logic                            has_pick;
  logic [IDX_W-1:0]                pick_idx;
  logic [BUTTON_COUNT-1:0]         rest;

  // Lowest pending button
  always_comb begin
    has_pick = 1'b0;
    pick_idx = '0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        has_pick = 1'b1;
        pick_idx = IDX_W'(i);
      end
    end
  end

  assign rest = mask_r & ~(BUTTON_COUNT'(1) << pick_idx);
  assign adv  = !out_valid_r || out_ready;

  // Refill from the queue when idle or as the last pending event leaves
  assign q_pop = !q_stat.empty && (!has_pick || (adv && (rest == '0)));

  always_comb begin
    out_valid_nxt = out_valid_r;
    mask_nxt      = mask_r;
    if (adv) begin
      out_valid_nxt = has_pick;
      mask_nxt      = rest;
    end
    if (q_pop) begin
      mask_nxt = q_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      evs_r <= q_data;
    end
    if (adv && has_pick) begin
      idx_r     <= pick_idx;
      evt_out_r <= evs_r[pick_idx];
      last_r    <= (rest == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_index = idx_r;
  assign out_event_kind   = evt_out_r.kind;
  assign out_press_count  = evt_out_r.count;
  assign out_last_event   = last_r;

endmodule : bda_back

`default_nettype wire

// ===== verif/button_debounce_autorepeat_core_tb.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core_tb
// Self-checking bench for the five-button debounce / autorepeat core. A
// directed script walks press, repress, release and repeat, zero-valued
// timers and the widest repress window. Randomized phases then hold random
// button patterns under several register settings.
// Every tick request runs through a cycle-free behavioral model of the
// buttons, and each event leaving the core is compared with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int BTN_COUNT     = 5;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 20;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } row_check_t;

  typedef struct packed {
    logic [2:0]       idx;
    ev_kind_t         kind;
    logic [CNT_W-1:0] count;
    logic             last;
  } button_event_t;

  typedef struct packed {
    logic             cfg_en;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_val;
    logic [4:0]       raw;
    logic [16:0]      reps;
    row_check_t       chk;
    logic [2:0]       idx;
    ev_kind_t         kind;
    logic [CNT_W-1:0] count;
  } directed_row_t;

  // Directed script: a row either writes a register or holds raw levels for
  // reps ticks. Typed expectations apply to every tick of their row.
  localparam directed_row_t DIRECTED_ROWS [23] = '{
    // right after reset, with reset register values
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd2, CHK_NONE, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h01, 17'd25, CHK_NONE, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h01, 17'd1, CHK_ONE, 3'd0, EV_PRESS, 16'd0},
    // zero debounce/repeat timers (upper data bits set on debounce write), widest window
    '{1'b1, CFG_DEBOUNCE, 12'hC00, 5'h00, 17'd0, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b1, CFG_FIRST_REPEAT, 12'd2, 5'h00, 17'd0, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b1, CFG_REPEAT, 12'd0, 5'h00, 17'd0, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b1, CFG_REPRESS_WIN, 12'hFFF, 5'h00, 17'd0, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // release of the button pressed at reset settings
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd1, CHK_NONE, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd1, CHK_ONE, 3'd0, EV_RELEASE, 16'd0},
    // all buttons down, then repeats every tick
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd1, CHK_NONE, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd1, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd1, CHK_NONE, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // button 0 released and pressed again inside the window: repress
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1E, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // glitch on button 1 settles back to its stable level: no event
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1D, 17'd1, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h1F, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // only button 0 stays down
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h01, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // longer hold raises the count
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h01, 17'd6, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    // release, then press again inside the widest window: repress
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd4, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h01, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd2, CHK_MODEL, 3'd0, EV_PRESS, 16'd0},
    '{1'b0, CFG_DEBOUNCE, 12'h000, 5'h00, 17'd1, CHK_NONE, 3'd0, EV_PRESS, 16'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BTN_COUNT-1:0]   in_raw_levels = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             out_button_index;
  logic [1:0]             out_event_kind;
  logic [CNT_W-1:0]       out_press_count;
  logic                   out_last_event;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Model state
  logic [BTN_COUNT-1:0]   prev_raw;
  logic                   stable_lvl [BTN_COUNT];
  logic [DB_W-1:0]        db_left    [BTN_COUNT];
  logic                   db_run     [BTN_COUNT];
  logic [RPT_W-1:0]       rpt_left   [BTN_COUNT];
  logic                   rpt_run    [BTN_COUNT];
  logic [SINCE_W-1:0]     since_rel  [BTN_COUNT];
  logic [CNT_W-1:0]       hold_cnt   [BTN_COUNT];
  logic [DB_W-1:0]        db_ticks;
  logic [RPT_W-1:0]       first_rpt_ticks;
  logic [RPT_W-1:0]       rpt_ticks;
  logic [SINCE_W-1:0]     win_ticks;

  button_event_t tick_events[$];
  button_event_t pending_events[$];

  // Checking mode of the row being driven
  row_check_t    row_check = CHK_MODEL;
  button_event_t row_event;

  int tick_gap_pct  = 0;
  int out_stall_pct = 0;
  int fail_count     = 0;
  int ticks_sent     = 0;
  int events_checked = 0;
  int kind_seen [4]  = '{0, 0, 0, 0};

  button_debounce_autorepeat_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_levels    (in_raw_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_event_kind   (out_event_kind),
    .out_press_count  (out_press_count),
    .out_last_event   (out_last_event),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Event receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Debounce and autorepeat of one tick; events go to tick_events
  task automatic debounce_tick(input logic [BTN_COUNT-1:0] raw);
    logic [BTN_COUNT-1:0]   chg;
    logic                   fresh;
    chg      = raw ^ prev_raw;
    prev_raw = raw;
    for (int b = 0; b < BTN_COUNT; b++) begin
      fresh = 1'b0;
      if (since_rel[b] != SINCE_MAX) since_rel[b] = since_rel[b] + 1'b1;

      // debounce: an edge restarts the timer, expiry samples the level
      if (chg[b]) begin
        db_left[b] = db_ticks;
        db_run[b]  = 1'b1;
      end else if (db_run[b]) begin
        if (db_left[b] <= 1) begin
          db_left[b] = '0;
          db_run[b]  = 1'b0;
          if (raw[b] != stable_lvl[b]) begin
            stable_lvl[b] = raw[b];
            if (raw[b]) begin
              rpt_left[b] = first_rpt_ticks;
              rpt_run[b]  = 1'b1;
              fresh       = 1'b1;
              if (since_rel[b] < win_ticks && hold_cnt[b] != 0) begin
                tick_events.push_back('{3'(b), EV_REPRESS, hold_cnt[b], 1'b0});
              end else begin
                hold_cnt[b] = '0;
                tick_events.push_back('{3'(b), EV_PRESS, 16'd0, 1'b0});
              end
            end else begin
              since_rel[b] = '0;
              rpt_run[b]   = 1'b0;
              rpt_left[b]  = '0;
              tick_events.push_back('{3'(b), EV_RELEASE, hold_cnt[b], 1'b0});
            end
          end
        end else begin
          db_left[b] = db_left[b] - 1'b1;
        end
      end

      // autorepeat, skipped on the tick the timer was loaded
      if (rpt_run[b] && !fresh) begin
        if (rpt_left[b] <= 1) begin
          if (stable_lvl[b]) begin
            rpt_left[b] = rpt_ticks;
            if (hold_cnt[b] != COUNT_MAX) hold_cnt[b] = hold_cnt[b] + 1'b1;
            tick_events.push_back('{3'(b), EV_REPEAT, hold_cnt[b], 1'b0});
          end else begin
            rpt_run[b]  = 1'b0;
            rpt_left[b] = '0;
          end
        end else begin
          rpt_left[b] = rpt_left[b] - 1'b1;
        end
      end
    end
    if (tick_events.size() != 0) tick_events[tick_events.size() - 1].last = 1'b1;
  endtask

  // Model update on accepted requests and checking of events
  always @(posedge clk) begin : scoreboard
    button_event_t want;
    if (!rst_n) begin
      prev_raw        = '0;
      db_ticks        = DEBOUNCE_RST;
      first_rpt_ticks = FIRST_REPEAT_RST;
      rpt_ticks       = REPEAT_RST;
      win_ticks       = REPRESS_WIN_RST;
      for (int b = 0; b < BTN_COUNT; b++) begin
        stable_lvl[b] = 1'b0;
        db_left[b]    = '0;
        db_run[b]     = 1'b0;
        rpt_left[b]   = '0;
        rpt_run[b]    = 1'b0;
        since_rel[b]  = SINCE_MAX;
        hold_cnt[b]   = '0;
      end
    end else begin
      // register write request
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE:     db_ticks        = cfg_data[DB_W-1:0];
          CFG_FIRST_REPEAT: first_rpt_ticks = cfg_data[RPT_W-1:0];
          CFG_REPEAT:       rpt_ticks       = cfg_data[RPT_W-1:0];
          CFG_REPRESS_WIN:  win_ticks       = cfg_data[SINCE_W-1:0];
          default: ;
        endcase
      end

      // tick request
      if (in_valid && in_ready) begin
        tick_events.delete();
        debounce_tick(in_raw_levels);
        ticks_sent++;
        case (row_check)
          CHK_MODEL: foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
          CHK_ONE:   pending_events.push_back(row_event);
          default: ;
        endcase
      end

      // event out
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected event button %0d kind %0d count %0d last %0b",
                     $time, out_button_index, out_event_kind, out_press_count,
                     out_last_event);
        end else begin
          want = pending_events.pop_front();
          events_checked++;
          kind_seen[want.kind]++;
          if (want.idx !== out_button_index || want.kind !== out_event_kind ||
              want.count !== out_press_count || want.last !== out_last_event) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: event mismatch: expected button %0d kind %0d count %0d ",
                        "last %0b, got button %0d kind %0d count %0d last %0b"},
                       $time, want.idx, want.kind, want.count, want.last,
                       out_button_index, out_event_kind, out_press_count,
                       out_last_event);
          end
        end
      end
    end
  end

  // One tick request; called and returns at a falling edge
  task automatic send_tick(input logic [BTN_COUNT-1:0] raw);
    while ($urandom_range(0, 99) < tick_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_levels <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off ticks until every predicted event is out and the core is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random phase: mostly held patterns long enough to debounce and repeat,
  // mixed with short holds that restart the timers and noise bursts
  task automatic run_phase(input logic [CFG_W-1:0] db_val, first_val, rpt_val, win_val,
                           input int budget);
    int               db_eff;
    int               span;
    int               len;
    int               sent;
    logic [BTN_COUNT-1:0] pat;
    wait_drained();
    write_reg(CFG_DEBOUNCE, db_val);
    write_reg(CFG_FIRST_REPEAT, first_val);
    write_reg(CFG_REPEAT, rpt_val);
    write_reg(CFG_REPRESS_WIN, win_val);
    db_eff = (db_val[DB_W-1:0] == 0) ? 1 : int'(db_val[DB_W-1:0]);
    span   = ((first_val == 0) ? 1 : int'(first_val)) + 3 * ((rpt_val == 0) ? 1 : int'(rpt_val));
    if (span > 40) span = 40;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 29) == 0) wait_drained();
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3);
        repeat (len) send_tick(BTN_COUNT'($urandom));
        sent += len;
      end
      pat = BTN_COUNT'($urandom);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, db_eff);
      else len = db_eff + $urandom_range(0, span);
      repeat (len) send_tick(pat);
      sent += len;
    end
  endtask

  initial begin
    int drain_wait;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed script, sender 23% idle, receiver 75% stalled
    tick_gap_pct  = 23;
    out_stall_pct = 75;
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].cfg_en) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[r].cfg_idx, DIRECTED_ROWS[r].cfg_val);
      end else begin
        row_check = DIRECTED_ROWS[r].chk;
        row_event = '{DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].kind,
                      DIRECTED_ROWS[r].count, 1'b1};
        repeat (DIRECTED_ROWS[r].reps) send_tick(DIRECTED_ROWS[r].raw);
      end
    end
    row_check = CHK_MODEL;

    // random phases across settings, shortest timers and longest repeat timers included
    run_phase(12'd1, 12'd1, 12'd1, 12'd1, 65);
    run_phase(12'd3, 12'd5, 12'd2, 12'd40, 65);
    tick_gap_pct  = 75;
    out_stall_pct = 23;
    run_phase(12'd6, 12'hFFF, 12'hFFF, 12'hFFF, 65);
    run_phase(12'd2, 12'd0, 12'd3, 12'hFFF, 65);
    tick_gap_pct  = 0;
    out_stall_pct = 0;
    run_phase(12'hC01, 12'd3, 12'd1, 12'd8, 65);

    // drain with a bound, then let the pipeline settle
    in_valid <= 1'b0;
    drain_wait = 0;
    while (pending_events.size() != 0 && drain_wait < 20000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d predicted events never came out", $time, pending_events.size());
      fail_count += pending_events.size();
    end

    $display("Run covered %0d tick requests and %0d checked events under seven register settings.",
             ticks_sent, events_checked);
    $display("Events by kind: press %0d, repress %0d, release %0d, repeat %0d.",
             kind_seen[EV_PRESS], kind_seen[EV_REPRESS], kind_seen[EV_RELEASE],
             kind_seen[EV_REPEAT]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("%0t: watchdog expired", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
